>>> src/cbq_pkg.sv
package cbq_pkg;

  localparam int MaxSections = 8;
  localparam int SampleW     = 16;
  localparam int DlyW        = 24;
  localparam int CoefW       = 16;
  localparam int GainW       = 16;
  localparam int CoefFrac    = 14;
  localparam int GainFrac    = 12;
  localparam int NumSlots    = 5;

  localparam int SecIdxW  = (MaxSections > 1) ? $clog2(MaxSections) : 1;
  localparam int SecCntW  = $clog2(MaxSections + 1);
  localparam int ProdW    = CoefW + DlyW;
  localparam int AccW     = ProdW + 2;
  localparam int CoefRowW = NumSlots * CoefW;
  localparam int DlyRowW  = 2 * DlyW;

  localparam int KindW    = 1;
  localparam int CsecW    = 3;
  localparam int CslotW   = 3;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;
  localparam int SectW    = 4;

  // coefficient slots within one section row
  localparam logic [CslotW-1:0] SlotB0 = 3'd0;
  localparam logic [CslotW-1:0] SlotB1 = 3'd1;
  localparam logic [CslotW-1:0] SlotB2 = 3'd2;
  localparam logic [CslotW-1:0] SlotA1 = 3'd3;
  localparam logic [CslotW-1:0] SlotA2 = 3'd4;

  localparam logic [KindW-1:0] KindSample = 1'b0;
  localparam logic [KindW-1:0] KindCoef   = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgGain     = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgSections = 4'd1;

  localparam logic signed [GainW-1:0] GainReset = 16'sd4096;
  localparam logic [SectW-1:0]        SectReset = 4'd1;

  typedef enum logic [2:0] {
    AccHold     = 3'd0,
    AccLoadX    = 3'd1,
    AccSub      = 3'd2,
    AccAdd      = 3'd3,
    AccLoadProd = 3'd4
  } acc_op_e;

  typedef struct packed {
    logic    mul_en;
    acc_op_e acc_op;
  } mac_ctrl_t;

endpackage

>>> src/cascaded_biquad_iir_filter.sv
// channel   dir  handshake              payload
// in        in   in_valid_i/in_ready_o  kind_i sample_i coef_section_i coef_slot_i coef_value_i
// out       out  out_valid_o/out_ready_i filtered_sample_o
// cfg       in   cfg_valid_i/cfg_ready_o cfg_index_i cfg_data_i
//
// sample beats are accepted only in idle, once the last has passed its gain step;
// each section is nine steps around one shared 16x24 multiplier and accumulator,
// with the section's coefficient row and delay row read from the two section rams
// coefficient beats are a row read, merge and write back; a bad address is dropped
// reset clears the row valid bits, so both rams read as zero until written
// a finished result waits in the output register; only the gain step stalls on it
module cascaded_biquad_iir_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cbq_pkg::KindW-1:0]           kind_i,
  input  logic signed [cbq_pkg::SampleW-1:0]  sample_i,
  input  logic [cbq_pkg::CsecW-1:0]           coef_section_i,
  input  logic [cbq_pkg::CslotW-1:0]          coef_slot_i,
  input  logic signed [cbq_pkg::CoefW-1:0]    coef_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cbq_pkg::SampleW-1:0]  filtered_sample_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cbq_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [cbq_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int SecIdxW = cbq_pkg::SecIdxW;
  localparam int SecCntW = cbq_pkg::SecCntW;
  localparam int CoefW   = cbq_pkg::CoefW;
  localparam int DlyW    = cbq_pkg::DlyW;
  localparam int NSec    = cbq_pkg::MaxSections;

  typedef enum logic [13:0] {
    StIdle   = 14'b00000000000001,
    StRead   = 14'b00000000000010,
    StLoad   = 14'b00000000000100,
    StMa1    = 14'b00000000001000,
    StMa2    = 14'b00000000010000,
    StMb1    = 14'b00000000100000,
    StVsat   = 14'b00000001000000,
    StMb2    = 14'b00000010000000,
    StMb0    = 14'b00000100000000,
    StYsat   = 14'b00001000000000,
    StGain   = 14'b00010000000000,
    StGsat   = 14'b00100000000000,
    StCread  = 14'b01000000000000,
    StCwrite = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [SecIdxW-1:0] k_q;
  logic [SecCntW-1:0] n_q, n_eff;
  logic [NSec-1:0]    coef_vld_q, dly_vld_q;
  logic               coef_rvld_q, dly_rvld_q;
  logic               out_valid_q;
  logic               gsat_go, last_sec, addr_ok, in_acc;

  logic signed [cbq_pkg::GainW-1:0] gain_q;
  logic [cbq_pkg::SectW-1:0]        sect_q;

  logic signed [DlyW-1:0]    x_q, v_q, v1_q, v2_q;
  logic signed [CoefW-1:0]   c_q [cbq_pkg::NumSlots];
  logic [SecIdxW-1:0]        csec_q;
  logic [cbq_pkg::CslotW-1:0] cslot_q;
  logic signed [CoefW-1:0]   cval_q;
  logic signed [cbq_pkg::SampleW-1:0] out_data_q;

  logic                         coef_re, coef_we, dly_re, dly_we;
  logic [SecIdxW-1:0]           coef_raddr;
  logic [cbq_pkg::CoefRowW-1:0] coef_rdata, coef_wdata;
  logic [cbq_pkg::DlyRowW-1:0]  dly_rdata, dly_wdata;

  cbq_pkg::mac_ctrl_t        mac_ctrl;
  logic signed [CoefW-1:0]   mul_a;
  logic signed [DlyW-1:0]    mul_b;
  logic signed [DlyW-1:0]    acc_sat;
  logic signed [cbq_pkg::SampleW-1:0] gain_sat;

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign filtered_sample_o = out_data_q;

  assign n_eff    = (int'(sect_q) > NSec) ? SecCntW'(NSec) : SecCntW'(sect_q);
  assign addr_ok  = (int'(coef_section_i) < NSec) && (coef_slot_i <= cbq_pkg::SlotA2);
  assign last_sec = ((SecCntW'(k_q) + SecCntW'(1)) == n_q);
  assign gsat_go  = (state_q == StGsat) && (!out_valid_q || out_ready_i);

  // section rams: one row per section
  assign coef_re    = (state_q == StRead) || (state_q == StCread);
  assign coef_raddr = (state_q == StCread) ? csec_q : k_q;
  assign coef_we    = (state_q == StCwrite);
  assign dly_re     = (state_q == StRead);
  assign dly_we     = (state_q == StYsat);
  assign dly_wdata  = {v1_q, v_q};

  always_comb begin
    coef_wdata = coef_rvld_q ? coef_rdata : '0;
    coef_wdata[cslot_q*CoefW +: CoefW] = cval_q;
  end

  cbq_ram #(
    .Width (cbq_pkg::CoefRowW),
    .Depth (NSec)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (csec_q),
    .wdata_i (coef_wdata),
    .re_i    (coef_re),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  cbq_ram #(
    .Width (cbq_pkg::DlyRowW),
    .Depth (NSec)
  ) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (dly_we),
    .waddr_i (k_q),
    .wdata_i (dly_wdata),
    .re_i    (dly_re),
    .raddr_i (k_q),
    .rdata_o (dly_rdata)
  );

  // operand and accumulator schedule of one section
  always_comb begin
    mul_a = c_q[cbq_pkg::SlotA1];
    mul_b = v1_q;
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_op = cbq_pkg::AccHold;
    case (state_q)
      StLoad: begin
        mac_ctrl.acc_op = cbq_pkg::AccLoadX;
      end
      StMa1: begin
        mac_ctrl.mul_en = 1'b1;
      end
      StMa2: begin
        mul_a = c_q[cbq_pkg::SlotA2];
        mul_b = v2_q;
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = cbq_pkg::AccSub;
      end
      StMb1: begin
        mul_a = c_q[cbq_pkg::SlotB1];
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = cbq_pkg::AccSub;
      end
      StVsat: begin
        mul_a = c_q[cbq_pkg::SlotB2];
        mul_b = v2_q;
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = cbq_pkg::AccLoadProd;
      end
      StMb2: begin
        mul_a = c_q[cbq_pkg::SlotB0];
        mul_b = v_q;
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = cbq_pkg::AccAdd;
      end
      StMb0: begin
        mac_ctrl.acc_op = cbq_pkg::AccAdd;
      end
      StGain: begin
        mul_a = gain_q;
        mul_b = x_q;
        mac_ctrl.mul_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  cbq_mac u_mac (
    .clk_i      (clk_i),
    .ctrl_i     (mac_ctrl),
    .mul_a_i    (mul_a),
    .mul_b_i    (mul_b),
    .x_i        (x_q),
    .acc_sat_o  (acc_sat),
    .gain_sat_o (gain_sat)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (kind_i == cbq_pkg::KindCoef) begin
            state_d = addr_ok ? StCread : StIdle;
          end else begin
            state_d = (n_eff == '0) ? StGain : StRead;
          end
        end
      end
      StRead:   state_d = StLoad;
      StLoad:   state_d = StMa1;
      StMa1:    state_d = StMa2;
      StMa2:    state_d = StMb1;
      StMb1:    state_d = StVsat;
      StVsat:   state_d = StMb2;
      StMb2:    state_d = StMb0;
      StMb0:    state_d = StYsat;
      StYsat:   state_d = last_sec ? StGain : StRead;
      StGain:   state_d = StGsat;
      StGsat: begin
        if (gsat_go) begin
          state_d = StIdle;
        end
      end
      StCread:  state_d = StCwrite;
      StCwrite: state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      k_q         <= '0;
      n_q         <= '0;
      coef_vld_q  <= '0;
      dly_vld_q   <= '0;
      coef_rvld_q <= 1'b0;
      dly_rvld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      gain_q      <= cbq_pkg::GainReset;
      sect_q      <= cbq_pkg::SectReset;
    end else begin
      state_q <= state_d;
      if (in_acc && (kind_i == cbq_pkg::KindSample)) begin
        k_q <= '0;
        n_q <= n_eff;
      end
      if (state_q == StYsat) begin
        k_q <= k_q + SecIdxW'(1);
        dly_vld_q[k_q] <= 1'b1;
      end
      if (coef_we) begin
        coef_vld_q[csec_q] <= 1'b1;
      end
      if (coef_re) begin
        coef_rvld_q <= coef_vld_q[coef_raddr];
      end
      if (dly_re) begin
        dly_rvld_q <= dly_vld_q[k_q];
      end
      out_valid_q <= (out_valid_q && !out_ready_i) || gsat_go;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cbq_pkg::CfgGain:     gain_q <= cfg_data_i;
          cbq_pkg::CfgSections: sect_q <= cfg_data_i[cbq_pkg::SectW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q     <= DlyW'(sample_i);
      csec_q  <= SecIdxW'(coef_section_i);
      cslot_q <= coef_slot_i;
      cval_q  <= coef_value_i;
    end
    if (state_q == StLoad) begin
      for (int i = 0; i < cbq_pkg::NumSlots; i++) begin
        c_q[i] <= coef_rvld_q ? coef_rdata[i*CoefW +: CoefW] : '0;
      end
      v1_q <= dly_rvld_q ? dly_rdata[DlyW-1:0] : '0;
      v2_q <= dly_rvld_q ? dly_rdata[2*DlyW-1:DlyW] : '0;
    end
    if (state_q == StVsat) begin
      v_q <= acc_sat;
    end
    if (state_q == StYsat) begin
      x_q <= acc_sat;
    end
    if (gsat_go) begin
      out_data_q <= gain_sat;
    end
  end

  a_dly_we_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dly_we |-> (SecCntW'(k_q) < n_q))
    else $error("delay row written beyond the sections in use");

  a_ram_we_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dly_we && coef_we))
    else $error("both section rams written in one cycle");

  a_coef_slot_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef_we |-> (cslot_q <= cbq_pkg::SlotA2))
    else $error("coefficient merge with a bad slot");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gsat_go |=> (out_valid_q && (state_q == StIdle)))
    else $error("gain result not presented");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |=> (state_q == StLoad) && !in_ready_o)
    else $error("section step sequence broken");

endmodule

>>> src/cbq_ram.sv
module cbq_ram #(
  parameter int Width = 8,
  parameter int Depth = 2,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/cbq_mac.sv
module cbq_mac (
  input  logic                              clk_i,
  input  cbq_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [cbq_pkg::CoefW-1:0]  mul_a_i,
  input  logic signed [cbq_pkg::DlyW-1:0]   mul_b_i,
  input  logic signed [cbq_pkg::DlyW-1:0]   x_i,
  output logic signed [cbq_pkg::DlyW-1:0]   acc_sat_o,
  output logic signed [cbq_pkg::SampleW-1:0] gain_sat_o
);

  localparam int AccW    = cbq_pkg::AccW;
  localparam int ProdW   = cbq_pkg::ProdW;
  localparam int DlyW    = cbq_pkg::DlyW;
  localparam int SampleW = cbq_pkg::SampleW;

  localparam logic signed [AccW-1:0]  AccHalf  = AccW'(1) <<< (cbq_pkg::CoefFrac - 1);
  localparam logic signed [ProdW-1:0] GainHalf = ProdW'(1) <<< (cbq_pkg::GainFrac - 1);
  localparam logic signed [DlyW-1:0]    DlyMax  = {1'b0, {(DlyW-1){1'b1}}};
  localparam logic signed [DlyW-1:0]    DlyMin  = {1'b1, {(DlyW-1){1'b0}}};
  localparam logic signed [SampleW-1:0] SmpMax  = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SmpMin  = {1'b1, {(SampleW-1){1'b0}}};

  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [AccW-1:0]  acc_d, acc_q;
  logic signed [AccW-1:0]  prod_ext, x_ext, acc_rnd;
  logic signed [ProdW-1:0] gain_rnd;
  logic                    acc_fits, gain_fits;

  assign prod_d   = ProdW'(mul_a_i) * ProdW'(mul_b_i);
  assign prod_ext = AccW'(prod_q);
  assign x_ext    = AccW'(x_i) <<< cbq_pkg::CoefFrac;

  always_comb begin
    case (ctrl_i.acc_op)
      cbq_pkg::AccLoadX:    acc_d = x_ext;
      cbq_pkg::AccSub:      acc_d = acc_q - prod_ext;
      cbq_pkg::AccAdd:      acc_d = acc_q + prod_ext;
      cbq_pkg::AccLoadProd: acc_d = prod_ext;
      default:              acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  // round half up, then clamp to the delay width
  assign acc_rnd  = (acc_q + AccHalf) >>> cbq_pkg::CoefFrac;
  assign acc_fits = (acc_rnd[AccW-1:DlyW-1] == '0) || (acc_rnd[AccW-1:DlyW-1] == '1);
  assign acc_sat_o = acc_fits ? acc_rnd[DlyW-1:0] : (acc_rnd[AccW-1] ? DlyMin : DlyMax);

  assign gain_rnd  = (prod_q + GainHalf) >>> cbq_pkg::GainFrac;
  assign gain_fits = (gain_rnd[ProdW-1:SampleW-1] == '0) ||
                     (gain_rnd[ProdW-1:SampleW-1] == '1);
  assign gain_sat_o = gain_fits ? gain_rnd[SampleW-1:0] : (gain_rnd[ProdW-1] ? SmpMin : SmpMax);

endmodule
